### sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a reset that disables it.
`define KGFQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define KGFQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/kgfq_pkg.sv
// Package for the grouped FIFO queue: defaults, codes, states and control types.
package kgfq_pkg;

   localparam int ENTRIES_DEFAULT = 1024;
   localparam int GROUPS_DEFAULT  = 256;
   localparam int KEY_W           = 32;
   localparam int SEQ_W           = 32;
   localparam int STATUS_W        = 2;

   // Result status codes
   localparam logic [STATUS_W-1:0] RSP_ACCEPTED = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_SERVED   = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] RSP_DROPPED  = 2'd3;

   // Request mode codes
   localparam logic MODE_ARRIVE = 1'b0;
   localparam logic MODE_SERVE  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_NOMATCH,
      ST_JOIN_RD,
      ST_JOIN_LINK,
      ST_JOIN_TAIL,
      ST_NEW,
      ST_SRV_RD,
      ST_SRV_POP,
      ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_SCAN_STEP,
      OP_JOIN_READ,
      OP_JOIN_LINK,
      OP_JOIN_TAIL,
      OP_NEW_GROUP,
      OP_SERVE_READ,
      OP_SERVE_POP,
      OP_RESULT_DROP,
      OP_RESULT_EMPTY
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load_rsp;
   } cmd_type;

   typedef struct packed {
      logic is_serve;
      logic store_full;
      logic empty;
      logic scan_done;
      logic key_match;
      logic group_full;
      logic rsp_free;
   } stat_type;

endpackage

### sv/kgfq_ctrl.sv
// Controller state machine: sequences the scan, link and serve steps of each item.
module kgfq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  kgfq_pkg::stat_type  stat,
   output kgfq_pkg::cmd_type   cmd
);

   kgfq_pkg::state_type state_ff, state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kgfq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pick next state and command
   always_comb begin
      state_in     = state_ff;
      cmd.op       = kgfq_pkg::OP_NONE;
      cmd.load_rsp = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         kgfq_pkg::ST_IDLE: begin
            // Take no item while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.op   = kgfq_pkg::OP_CAPTURE;
               state_in = kgfq_pkg::ST_DECIDE;
            end
         end
         kgfq_pkg::ST_DECIDE: begin
            if (stat.is_serve) begin
               if (stat.empty) begin
                  cmd.op   = kgfq_pkg::OP_RESULT_EMPTY;
                  state_in = kgfq_pkg::ST_RESP;
               end else begin
                  state_in = kgfq_pkg::ST_SRV_RD;
               end
            end else if (stat.store_full) begin
               cmd.op   = kgfq_pkg::OP_RESULT_DROP;
               state_in = kgfq_pkg::ST_RESP;
            end else begin
               state_in = kgfq_pkg::ST_SCAN_RD;
            end
         end
         kgfq_pkg::ST_SCAN_RD: begin
            state_in = stat.scan_done ? kgfq_pkg::ST_NOMATCH : kgfq_pkg::ST_SCAN_CMP;
         end
         kgfq_pkg::ST_SCAN_CMP: begin
            if (stat.key_match) begin
               state_in = kgfq_pkg::ST_JOIN_RD;
            end else begin
               cmd.op   = kgfq_pkg::OP_SCAN_STEP;
               state_in = kgfq_pkg::ST_SCAN_RD;
            end
         end
         kgfq_pkg::ST_NOMATCH: begin
            if (stat.group_full) begin
               cmd.op   = kgfq_pkg::OP_RESULT_DROP;
               state_in = kgfq_pkg::ST_RESP;
            end else begin
               state_in = kgfq_pkg::ST_NEW;
            end
         end
         kgfq_pkg::ST_JOIN_RD: begin
            cmd.op   = kgfq_pkg::OP_JOIN_READ;
            state_in = kgfq_pkg::ST_JOIN_LINK;
         end
         kgfq_pkg::ST_JOIN_LINK: begin
            cmd.op   = kgfq_pkg::OP_JOIN_LINK;
            state_in = kgfq_pkg::ST_JOIN_TAIL;
         end
         kgfq_pkg::ST_JOIN_TAIL: begin
            cmd.op   = kgfq_pkg::OP_JOIN_TAIL;
            state_in = kgfq_pkg::ST_RESP;
         end
         kgfq_pkg::ST_NEW: begin
            cmd.op   = kgfq_pkg::OP_NEW_GROUP;
            state_in = kgfq_pkg::ST_RESP;
         end
         kgfq_pkg::ST_SRV_RD: begin
            cmd.op   = kgfq_pkg::OP_SERVE_READ;
            state_in = kgfq_pkg::ST_SRV_POP;
         end
         kgfq_pkg::ST_SRV_POP: begin
            cmd.op   = kgfq_pkg::OP_SERVE_POP;
            state_in = kgfq_pkg::ST_RESP;
         end
         kgfq_pkg::ST_RESP: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = kgfq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kgfq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### sv/kgfq_dp.sv
// Datapath: item and group memories, queue pointers, free-slot stack and result register.
module kgfq_dp #(
   parameter int ENTRIES = kgfq_pkg::ENTRIES_DEFAULT,
   parameter int GROUPS  = kgfq_pkg::GROUPS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_mode,
   input  logic [kgfq_pkg::KEY_W-1:0]    req_key,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [kgfq_pkg::STATUS_W-1:0] rsp_status,
   output logic [kgfq_pkg::SEQ_W-1:0]    rsp_served_seq,
   input  kgfq_pkg::cmd_type             cmd,
   output kgfq_pkg::stat_type            stat
);

   localparam int IW  = $clog2(ENTRIES);
   localparam int CW  = $clog2(ENTRIES + 1);
   localparam int GW  = $clog2(GROUPS);
   localparam int GCW = $clog2(GROUPS + 1);

   // Memories
   logic [kgfq_pkg::SEQ_W-1:0] seq_mem   [ENTRIES];
   logic [IW-1:0]              next_mem  [ENTRIES];
   logic [IW-1:0]              free_mem  [ENTRIES];
   logic [kgfq_pkg::KEY_W-1:0] gkey_mem  [GROUPS];
   logic [IW-1:0]              gtail_mem [GROUPS];
   logic [CW-1:0]              gcnt_mem  [GROUPS];

   // Control registers
   logic [CW-1:0]  fresh_ff, fresh_in;
   logic [CW-1:0]  sp_ff, sp_in;
   logic [IW-1:0]  head_ff, head_in;
   logic [IW-1:0]  tail_ff, tail_in;
   logic [CW-1:0]  total_ff, total_in;
   logic [kgfq_pkg::SEQ_W-1:0] seq_ff, seq_in;
   logic [GW-1:0]  gh_ff, gh_in;
   logic [GW-1:0]  gt_ff, gt_in;
   logic [GCW-1:0] gcnt_ff, gcnt_in;
   logic [GW-1:0]  scan_ff, scan_in;
   logic [GCW-1:0] rem_ff, rem_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic                          mode_ff;
   logic [kgfq_pkg::KEY_W-1:0]    key_ff;
   logic [kgfq_pkg::SEQ_W-1:0]    seq_rd_ff;
   logic [IW-1:0]                 next_rd_ff;
   logic [IW-1:0]                 free_rd_ff;
   logic [kgfq_pkg::KEY_W-1:0]    gkey_rd_ff;
   logic [IW-1:0]                 gtail_rd_ff;
   logic [CW-1:0]                 gcnt_rd_ff;
   logic [kgfq_pkg::STATUS_W-1:0] res_status_ff;
   logic [kgfq_pkg::SEQ_W-1:0]    res_seq_ff;
   logic [kgfq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [kgfq_pkg::SEQ_W-1:0]    rsp_seq_ff;

   logic [CW-1:0] sp_dec;
   logic [IW-1:0] alloc_slot;
   logic          use_fresh;
   logic [GW-1:0] grp_raddr;
   logic [IW-1:0] next_raddr;

   function automatic logic [GW-1:0] grp_inc(input logic [GW-1:0] idx);
      grp_inc = (idx == GW'(GROUPS - 1)) ? '0 : idx + GW'(1);
   endfunction

   // Choose the slot for a new item and the memory read addresses
   assign sp_dec     = sp_ff - CW'(1);
   assign use_fresh  = (fresh_ff < CW'(ENTRIES));
   assign alloc_slot = use_fresh ? fresh_ff[IW-1:0] : free_rd_ff;
   assign grp_raddr  = (cmd.op == kgfq_pkg::OP_SERVE_READ) ? gh_ff : scan_ff;
   assign next_raddr = (cmd.op == kgfq_pkg::OP_JOIN_READ) ? gtail_rd_ff : head_ff;

   // Report status to the controller
   assign stat.is_serve   = (mode_ff == kgfq_pkg::MODE_SERVE);
   assign stat.store_full = (total_ff == CW'(ENTRIES));
   assign stat.empty      = (total_ff == '0);
   assign stat.scan_done  = (rem_ff == '0);
   assign stat.key_match  = (gkey_rd_ff == key_ff);
   assign stat.group_full = (gcnt_ff == GCW'(GROUPS));
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   // Read the memories every cycle
   always_ff @(posedge clock) begin
      seq_rd_ff   <= seq_mem[head_ff];
      next_rd_ff  <= next_mem[next_raddr];
      free_rd_ff  <= free_mem[sp_dec[IW-1:0]];
      gkey_rd_ff  <= gkey_mem[grp_raddr];
      gtail_rd_ff <= gtail_mem[grp_raddr];
      gcnt_rd_ff  <= gcnt_mem[grp_raddr];
   end

   // Write the memories
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         kgfq_pkg::OP_JOIN_LINK: begin
            seq_mem[alloc_slot]  <= seq_ff;
            next_mem[alloc_slot] <= next_rd_ff;
         end
         kgfq_pkg::OP_JOIN_TAIL: begin
            next_mem[gtail_rd_ff] <= alloc_slot;
            gtail_mem[scan_ff]    <= alloc_slot;
            gcnt_mem[scan_ff]     <= gcnt_rd_ff + CW'(1);
         end
         kgfq_pkg::OP_NEW_GROUP: begin
            seq_mem[alloc_slot] <= seq_ff;
            if (total_ff != '0) begin
               next_mem[tail_ff] <= alloc_slot;
            end
            gkey_mem[gt_ff]  <= key_ff;
            gtail_mem[gt_ff] <= alloc_slot;
            gcnt_mem[gt_ff]  <= CW'(1);
         end
         kgfq_pkg::OP_SERVE_POP: begin
            free_mem[sp_ff[IW-1:0]] <= head_ff;
            gcnt_mem[gh_ff]         <= gcnt_rd_ff - CW'(1);
         end
         default: begin
         end
      endcase
   end

   // Capture the request and the pending result
   always_ff @(posedge clock) begin
      if (cmd.op == kgfq_pkg::OP_CAPTURE) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
      end
      unique case (cmd.op)
         kgfq_pkg::OP_RESULT_DROP: begin
            res_status_ff <= kgfq_pkg::RSP_DROPPED;
            res_seq_ff    <= '0;
         end
         kgfq_pkg::OP_RESULT_EMPTY: begin
            res_status_ff <= kgfq_pkg::RSP_EMPTY;
            res_seq_ff    <= '0;
         end
         kgfq_pkg::OP_JOIN_TAIL, kgfq_pkg::OP_NEW_GROUP: begin
            res_status_ff <= kgfq_pkg::RSP_ACCEPTED;
            res_seq_ff    <= '0;
         end
         kgfq_pkg::OP_SERVE_POP: begin
            res_status_ff <= kgfq_pkg::RSP_SERVED;
            res_seq_ff    <= seq_rd_ff;
         end
         default: begin
         end
      endcase
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_seq_ff    <= res_seq_ff;
      end
   end

   // Advance the pointers and counters
   always_comb begin
      fresh_in     = fresh_ff;
      sp_in        = sp_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      total_in     = total_ff;
      seq_in       = seq_ff;
      gh_in        = gh_ff;
      gt_in        = gt_ff;
      gcnt_in      = gcnt_ff;
      scan_in      = scan_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
      unique case (cmd.op)
         kgfq_pkg::OP_CAPTURE: begin
            scan_in = gh_ff;
            rem_in  = gcnt_ff;
            if (req_mode == kgfq_pkg::MODE_ARRIVE) begin
               seq_in = seq_ff + kgfq_pkg::SEQ_W'(1);
            end
         end
         kgfq_pkg::OP_SCAN_STEP: begin
            scan_in = grp_inc(scan_ff);
            rem_in  = rem_ff - GCW'(1);
         end
         kgfq_pkg::OP_JOIN_TAIL: begin
            if (gtail_rd_ff == tail_ff) begin
               tail_in = alloc_slot;
            end
            total_in = total_ff + CW'(1);
            if (use_fresh) begin
               fresh_in = fresh_ff + CW'(1);
            end else begin
               sp_in = sp_dec;
            end
         end
         kgfq_pkg::OP_NEW_GROUP: begin
            if (total_ff == '0) begin
               head_in = alloc_slot;
            end
            tail_in  = alloc_slot;
            total_in = total_ff + CW'(1);
            gt_in    = grp_inc(gt_ff);
            gcnt_in  = gcnt_ff + GCW'(1);
            if (use_fresh) begin
               fresh_in = fresh_ff + CW'(1);
            end else begin
               sp_in = sp_dec;
            end
         end
         kgfq_pkg::OP_SERVE_POP: begin
            head_in  = next_rd_ff;
            total_in = total_ff - CW'(1);
            sp_in    = sp_ff + CW'(1);
            if (gcnt_rd_ff == CW'(1)) begin
               gh_in   = grp_inc(gh_ff);
               gcnt_in = gcnt_ff - GCW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Hold the control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff     <= '0;
         sp_ff        <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         total_ff     <= '0;
         seq_ff       <= '0;
         gh_ff        <= '0;
         gt_ff        <= '0;
         gcnt_ff      <= '0;
         scan_ff      <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fresh_ff     <= fresh_in;
         sp_ff        <= sp_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         total_ff     <= total_in;
         seq_ff       <= seq_in;
         gh_ff        <= gh_in;
         gt_ff        <= gt_in;
         gcnt_ff      <= gcnt_in;
         scan_ff      <= scan_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_served_seq = rsp_seq_ff;

endmodule

### sv/key_grouped_fifo_queue_top.sv
// Top level of the grouped FIFO queue: the controller joined to the datapath.
// Each item is an arrival (keyed) or a serve. Waiting groups are kept in
// queue order; an arrival walks them from the front looking for its key,
// reading and then comparing each group's key in turn. A join then reads
// the group's tail, links the new item and updates the tail; a miss opens
// a new group, or drops the item when every group is in use. A serve reads
// and pops the head item; an empty serve or a drop on a full store goes
// straight to the result. One item is in work at a time and the block is
// ready again in the cycle after the result is loaded; the result register
// lets the next item enter while a result still waits to be taken, and an
// item whose result is done stalls only while the previous result is still
// held.
module key_grouped_fifo_queue_top #(
   parameter int ENTRIES = kgfq_pkg::ENTRIES_DEFAULT,
   parameter int GROUPS  = kgfq_pkg::GROUPS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic signed [kgfq_pkg::KEY_W-1:0] req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [kgfq_pkg::STATUS_W-1:0] rsp_status,
   output logic [kgfq_pkg::SEQ_W-1:0]    rsp_served_seq
);

   kgfq_pkg::cmd_type  cmd;
   kgfq_pkg::stat_type stat;

   kgfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   kgfq_dp #(
      .ENTRIES (ENTRIES),
      .GROUPS  (GROUPS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_mode),
      .req_key        (req_key),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_served_seq (rsp_served_seq),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

### sv/kgfq_checker.sv
// Port checker for the grouped FIFO queue and its bind to the top level.
`include "assert_macros.svh"

module kgfq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [kgfq_pkg::STATUS_W-1:0] rsp_status,
   input logic [kgfq_pkg::SEQ_W-1:0]    rsp_served_seq
);

   // Non-serve results carry no sequence number
   `KGFQ_ASSERT(a_seq_zero, clock, reset, (rsp_valid && rsp_status != kgfq_pkg::RSP_SERVED) |-> (rsp_served_seq == '0), "sequence set on non-serve result")
   // One item at a time: no new item right after one is taken
   `KGFQ_ASSERT(a_one_item, clock, reset, (req_valid && req_ready) |=> !req_ready, "item taken while another is in work")
   // A result never shows up in the cycle after an item enters
   `KGFQ_ASSERT(a_no_instant, clock, reset, (req_valid && req_ready && !rsp_valid) |=> !rsp_valid, "result too early")
   // A stalled result stays
   `KGFQ_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "result dropped while stalled")

endmodule

bind key_grouped_fifo_queue_top kgfq_checker u_kgfq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_served_seq (rsp_served_seq)
);

### bench/tb_key_grouped_fifo_queue_top.sv
// Testbench for the grouped FIFO queue: directed and random items checked against a predictor.
module tb_key_grouped_fifo_queue_top;

   localparam int NUM_ITEMS   = kgfq_pkg::ENTRIES_DEFAULT;
   localparam int NUM_GROUPS  = kgfq_pkg::GROUPS_DEFAULT;
   localparam int CYCLE_LIMIT = 20000000;

   typedef struct packed {
      logic [kgfq_pkg::STATUS_W-1:0] status;
      logic [kgfq_pkg::SEQ_W-1:0]    seq;
   } outcome_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic                                req_mode;
   logic signed [kgfq_pkg::KEY_W-1:0]   req_key;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [kgfq_pkg::STATUS_W-1:0]       rsp_status;
   logic [kgfq_pkg::SEQ_W-1:0]          rsp_served_seq;

   // Predictor state
   logic [kgfq_pkg::SEQ_W-1:0] slot_seq [NUM_ITEMS];
   int                         slot_link [NUM_ITEMS];
   int                         slot_owner [NUM_ITEMS];
   bit                         slot_free [NUM_ITEMS];
   logic [kgfq_pkg::KEY_W-1:0] team_key [NUM_GROUPS];
   int                         team_last [NUM_GROUPS];
   int                         team_size [NUM_GROUPS];
   bit                         team_live [NUM_GROUPS];
   int                         queue_head, queue_tail, waiting_total;
   logic [kgfq_pkg::SEQ_W-1:0] arrivals;

   outcome_type pending_outcomes[$];
   int          mismatches;
   int          cycles;
   int          send_idle_pct;
   int          recv_stall_pct;
   logic [kgfq_pkg::KEY_W-1:0] key_pool [8];

   key_grouped_fifo_queue_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_served_seq (rsp_served_seq)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Clear the team queue model
   function automatic void clear_team_queue();
      for (int i = 0; i < NUM_ITEMS; i++) slot_free[i] = 1'b1;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         team_live[g] = 1'b0;
         team_size[g] = 0;
      end
      queue_head = 0;
      queue_tail = 0;
      waiting_total = 0;
      arrivals = '0;
   endfunction

   // Advance the team queue model by one item and return its outcome
   function automatic outcome_type team_queue_step(logic mode,
                                                   logic [kgfq_pkg::KEY_W-1:0] key);
      outcome_type res;
      int slot, grp, free_grp, h, g, t;
      res = '0;
      if (mode == kgfq_pkg::MODE_ARRIVE) begin
         arrivals = arrivals + kgfq_pkg::SEQ_W'(1);
         slot = -1;
         grp = -1;
         free_grp = -1;
         for (int i = NUM_ITEMS - 1; i >= 0; i--) if (slot_free[i]) slot = i;
         for (int k = NUM_GROUPS - 1; k >= 0; k--) begin
            if (team_live[k] && team_key[k] == key) grp = k;
            if (!team_live[k]) free_grp = k;
         end
         if (slot < 0 || (grp < 0 && free_grp < 0)) begin
            res.status = kgfq_pkg::RSP_DROPPED;
            return res;
         end
         slot_free[slot] = 1'b0;
         slot_seq[slot] = arrivals;
         slot_link[slot] = 0;
         if (grp >= 0) begin
            t = team_last[grp];
            slot_link[slot] = slot_link[t];
            slot_link[t] = slot;
            if (t == queue_tail) queue_tail = slot;
            team_last[grp] = slot;
            team_size[grp]++;
         end else begin
            grp = free_grp;
            team_live[grp] = 1'b1;
            team_key[grp] = key;
            team_last[grp] = slot;
            team_size[grp] = 1;
            if (waiting_total == 0) queue_head = slot;
            else slot_link[queue_tail] = slot;
            queue_tail = slot;
         end
         slot_owner[slot] = grp;
         waiting_total++;
         res.status = kgfq_pkg::RSP_ACCEPTED;
         return res;
      end
      if (waiting_total == 0) begin
         res.status = kgfq_pkg::RSP_EMPTY;
         return res;
      end
      h = queue_head;
      g = slot_owner[h];
      res.status = kgfq_pkg::RSP_SERVED;
      res.seq = slot_seq[h];
      slot_free[h] = 1'b1;
      waiting_total--;
      if (team_size[g] > 0) team_size[g]--;
      if (team_size[g] == 0) team_live[g] = 1'b0;
      queue_head = slot_link[h];
      return res;
   endfunction

   // Send one item, idling at random first, and record its outcome on acceptance
   task automatic send_item(logic mode, logic [kgfq_pkg::KEY_W-1:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_key   <= key;
      do @(posedge clock); while (!req_ready);
      pending_outcomes.push_back(team_queue_step(mode, key));
   endtask

   // Hold off the sender until every outcome has arrived
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Check each result and stall the receiver at random
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: status %0d seq %0d", rsp_status,
                           rsp_served_seq);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_status !== want.status || rsp_served_seq !== want.seq) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected status %0d seq %0d, got status %0d seq %0d",
                              want.status, want.seq, rsp_status, rsp_served_seq);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // End the run on a hung block
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_key_grouped_fifo_queue_top NOT OK");
         $finish;
      end
   end

   // Extreme keys, joins behind existing groups, serve on empty
   task automatic test_directed();
      send_item(kgfq_pkg::MODE_SERVE, 32'h0);
      send_item(kgfq_pkg::MODE_ARRIVE, 32'hFFFF_FFFF);
      send_item(kgfq_pkg::MODE_ARRIVE, 32'h8000_0000);
      send_item(kgfq_pkg::MODE_ARRIVE, 32'h7FFF_FFFF);
      send_item(kgfq_pkg::MODE_ARRIVE, 32'hFFFF_FFFF);
      send_item(kgfq_pkg::MODE_ARRIVE, 32'h0000_0000);
      send_item(kgfq_pkg::MODE_ARRIVE, 32'h8000_0000);
      send_item(kgfq_pkg::MODE_ARRIVE, 32'hFFFF_FFFF);
      send_item(kgfq_pkg::MODE_SERVE, 32'hFFFF_FFFF);
      send_item(kgfq_pkg::MODE_ARRIVE, 32'hFFFF_FFFF);
      for (int i = 0; i < 9; i++) send_item(kgfq_pkg::MODE_SERVE, $urandom);
   endtask

   // Serve until the queue is empty
   task automatic test_drain();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      while (waiting_total != 0) send_item(kgfq_pkg::MODE_SERVE, '0);
   endtask

   // Use every group with distinct keys, overflow, then join an existing group
   task automatic test_groups_full();
      for (int i = 0; i < NUM_GROUPS + 2; i++)
         send_item(kgfq_pkg::MODE_ARRIVE, 32'h5A00_0000 + i);
      send_item(kgfq_pkg::MODE_ARRIVE, 32'h5A00_0001);
   endtask

   // Fill the remaining item slots by joining every group, overflow, serve a few, then arrive again
   task automatic test_store_full();
      for (int i = 0; i < NUM_ITEMS - NUM_GROUPS + 3; i++)
         send_item(kgfq_pkg::MODE_ARRIVE, 32'h5A00_0000 + (i % NUM_GROUPS));
      for (int i = 0; i < 4; i++) send_item(kgfq_pkg::MODE_SERVE, '0);
      send_item(kgfq_pkg::MODE_ARRIVE, 32'h1234_5678);
      send_item(kgfq_pkg::MODE_ARRIVE, 32'h5A00_00FF);
   endtask

   // Random arrivals, mostly from a small key pool, mixed with serves
   task automatic test_random(int count, int idle_pct, int stall_pct);
      logic [kgfq_pkg::KEY_W-1:0] key;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
      for (int i = 0; i < count; i++) begin
         key = ($urandom_range(99) < 10) ? $urandom : key_pool[$urandom_range(7)];
         if ($urandom_range(99) < 52) send_item(kgfq_pkg::MODE_ARRIVE, key);
         else send_item(kgfq_pkg::MODE_SERVE, $urandom);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = kgfq_pkg::MODE_ARRIVE;
      req_key = '0;
      rsp_ready = 1'b0;
      mismatches = 0;
      cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      clear_team_queue();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(180, 0, 0);
      wait_drained();
      test_random(180, 63, 0);
      test_random(180, 0, 63);
      test_random(180, 25, 25);
      test_drain();
      test_groups_full();
      test_store_full();
      wait_drained();
      repeat (600) @(posedge clock);
      if (mismatches == 0 && pending_outcomes.size() == 0)
         $display("tb_key_grouped_fifo_queue_top OK");
      else
         $display("tb_key_grouped_fifo_queue_top NOT OK");
      $finish;
   end
endmodule

### sim.f
+incdir+sv
sv/kgfq_pkg.sv
sv/kgfq_ctrl.sv
sv/kgfq_dp.sv
sv/key_grouped_fifo_queue_top.sv
sv/kgfq_checker.sv
bench/tb_key_grouped_fifo_queue_top.sv
